### hdl/oscillometric_bp_estimator_macros.svh
// assertion macros used by the checker file
// no dependencies; guarded against double inclusion
`ifndef OSCILLOMETRIC_BP_ESTIMATOR_MACROS_SVH
`define OSCILLOMETRIC_BP_ESTIMATOR_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define OBP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oscillometric_bp_estimator: assertion failed");

// next-cycle implication, off while reset is asserted
`define OBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oscillometric_bp_estimator: assertion failed");

`endif

### hdl/obp_pkg.sv
// shared constants, register codes and controller/datapath types
// no dependencies
`timescale 1ns / 1ps

package obp_pkg;

    localparam int DEPTH    = 2048;
    localparam int WIN_LEN  = 5;

    localparam int P_W      = 17;
    localparam int CFG_W    = 8;
    localparam int OUT_P_W  = P_W - 8;
    localparam int OSC_W    = P_W + 2;
    localparam int RAM_W    = P_W + OSC_W;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int WPOS_W   = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
    localparam int SUM_W    = P_W + WPOS_W;

    // floor(sum / WIN_LEN) as (sum * RECIP) >> DIV_SH, exact for any sum below 2**SUM_W
    localparam int DIV_SH   = SUM_W + WPOS_W;
    localparam int RECIP_W  = SUM_W + 1;
    localparam longint unsigned RECIP_VAL = ((64'd1 << DIV_SH) + WIN_LEN - 1) / WIN_LEN;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam int PROD_W   = SUM_W + RECIP_W;

    localparam int THR_W    = CFG_W + OSC_W - 1;
    localparam int CMP_W    = OSC_W + 9;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_OSC_OFFSET     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIA_RATIO_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIA_RATIO_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYS_RATIO_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYS_RATIO_HIGH = 3'd4;

    // register reset values
    localparam logic [CFG_W-1:0] RST_OSC_OFFSET     = 8'd179;
    localparam logic [CFG_W-1:0] RST_DIA_RATIO_LOW  = 8'd200;
    localparam logic [CFG_W-1:0] RST_DIA_RATIO_HIGH = 8'd212;
    localparam logic [CFG_W-1:0] RST_SYS_RATIO_LOW  = 8'd123;
    localparam logic [CFG_W-1:0] RST_SYS_RATIO_HIGH = 8'd136;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MEAN  = 7'b0000010,
        S_OSC   = 7'b0000100,
        S_PREP  = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_DRAIN = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic accept;   // take the input transaction
        logic mean;     // register window_sum * reciprocal
        logic osc;      // oscillation, store write, max update
        logic prep;     // band thresholds, scan start
        logic rd_en;    // scan read
        logic finish;   // load result, clear record
    } t_dp_cmd;

    typedef struct packed {
        logic room;       // record not full
        logic last;       // held sample closes the record
        logic long_rec;   // more than WIN_LEN samples kept
        logic scan_last;  // scan read at the final kept sample
        logic out_free;   // result register can take a new result
    } t_dp_stat;

endpackage

### hdl/obp_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module obp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/obp_ctrl.sv
// sequencing state machine: load steps per sample, then the record scan
// depends on obp_pkg
`timescale 1ns / 1ps

module obp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_last,
    output logic               o_in_stall,
    output obp_pkg::t_dp_cmd   o_cmd,
    input  obp_pkg::t_dp_stat  i_stat
);

    obp_pkg::t_state r_state;
    obp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= obp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            obp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.room) begin
                        n_state = obp_pkg::S_MEAN;
                    end else if (i_last) begin
                        n_state = obp_pkg::S_PREP;
                    end
                end
            end
            obp_pkg::S_MEAN: begin
                o_cmd.mean = 1'b1;
                n_state    = obp_pkg::S_OSC;
            end
            obp_pkg::S_OSC: begin
                o_cmd.osc = 1'b1;
                n_state   = i_stat.last ? obp_pkg::S_PREP : obp_pkg::S_IDLE;
            end
            obp_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_stat.long_rec ? obp_pkg::S_SCAN : obp_pkg::S_DONE;
            end
            obp_pkg::S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = obp_pkg::S_DRAIN;
                end
            end
            obp_pkg::S_DRAIN: begin
                n_state = obp_pkg::S_DONE;
            end
            obp_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = obp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = obp_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != obp_pkg::S_IDLE) || !i_rst_n;

endmodule

### hdl/obp_datapath.sv
// window mean, oscillation store, band thresholds, scan and result register
// depends on obp_pkg and obp_ram
`timescale 1ns / 1ps

module obp_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  obp_pkg::t_dp_cmd                i_cmd,
    output obp_pkg::t_dp_stat               o_stat,
    input  logic [obp_pkg::P_W-1:0]         i_pressure,
    input  logic                            i_last,
    input  logic                            i_cfg_valid,
    input  logic [obp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [obp_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [obp_pkg::OUT_P_W-1:0]     o_systolic_mmhg,
    output logic [obp_pkg::OUT_P_W-1:0]     o_diastolic_mmhg,
    output logic                            o_systolic_found,
    output logic                            o_diastolic_found,
    output logic [obp_pkg::CNT_W-1:0]       o_samples_kept
);

    // configuration
    logic [obp_pkg::CFG_W-1:0] r_osc_off;
    logic [obp_pkg::CFG_W-1:0] r_dlo;
    logic [obp_pkg::CFG_W-1:0] r_dhi;
    logic [obp_pkg::CFG_W-1:0] r_slo;
    logic [obp_pkg::CFG_W-1:0] r_shi;

    // record state
    logic [obp_pkg::P_W-1:0]    r_win [obp_pkg::WIN_LEN];
    logic [obp_pkg::WPOS_W-1:0] r_win_pos;
    logic [obp_pkg::SUM_W-1:0]  r_win_sum;
    logic [obp_pkg::CNT_W-1:0]  r_count;
    logic signed [obp_pkg::OSC_W-1:0] r_max;
    logic                       r_last;

    // load pipeline payload
    logic [obp_pkg::P_W-1:0]    r_p;
    logic [obp_pkg::PROD_W-1:0] r_prod;

    // scan
    logic [obp_pkg::THR_W-1:0]  r_thr_dlo;
    logic [obp_pkg::THR_W-1:0]  r_thr_dhi;
    logic [obp_pkg::THR_W-1:0]  r_thr_slo;
    logic [obp_pkg::THR_W-1:0]  r_thr_shi;
    logic [obp_pkg::CNT_W-1:0]  r_idx;
    logic                       r_eval;
    logic [obp_pkg::P_W-1:0]    r_sys;
    logic [obp_pkg::P_W-1:0]    r_dia;
    logic                       r_sys_f;
    logic                       r_dia_f;

    // result register
    logic                         r_out_valid;
    logic [obp_pkg::OUT_P_W-1:0]  r_o_sys;
    logic [obp_pkg::OUT_P_W-1:0]  r_o_dia;
    logic                         r_o_sf;
    logic                         r_o_df;
    logic [obp_pkg::CNT_W-1:0]    r_o_kept;

    logic [obp_pkg::SUM_W-1:0]        w_sum_next;
    logic [obp_pkg::P_W-1:0]          w_mean;
    logic signed [obp_pkg::OSC_W-1:0] w_osc;
    logic [obp_pkg::RAM_W-1:0]        w_rd_data;
    logic [obp_pkg::P_W-1:0]          w_rd_sample;
    logic signed [obp_pkg::OSC_W-1:0] w_rd_osc;
    logic signed [obp_pkg::CMP_W-1:0] w_osc_sh;
    logic                             w_in_dia;
    logic                             w_in_sys;
    logic [obp_pkg::OSC_W-2:0]        w_max_mag;

    always_comb begin
        o_stat.room      = r_count < obp_pkg::CNT_W'(obp_pkg::DEPTH);
        o_stat.last      = r_last;
        o_stat.long_rec  = r_count > obp_pkg::CNT_W'(obp_pkg::WIN_LEN);
        o_stat.scan_last = r_idx == (r_count - obp_pkg::CNT_W'(1));
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    assign w_sum_next = r_win_sum
                      - {{(obp_pkg::SUM_W - obp_pkg::P_W){1'b0}}, r_win[r_win_pos]}
                      + {{(obp_pkg::SUM_W - obp_pkg::P_W){1'b0}}, i_pressure};

    // mean = floor(window_sum / WIN_LEN)
    assign w_mean = r_prod[obp_pkg::DIV_SH +: obp_pkg::P_W];
    assign w_osc  = $signed({{(obp_pkg::OSC_W - obp_pkg::CFG_W){1'b0}}, r_osc_off})
                  + $signed({2'b00, r_p})
                  - $signed({2'b00, w_mean});

    assign w_max_mag   = r_max[obp_pkg::OSC_W-2:0];
    assign w_rd_sample = w_rd_data[obp_pkg::RAM_W-1 -: obp_pkg::P_W];
    assign w_rd_osc    = $signed(w_rd_data[obp_pkg::OSC_W-1:0]);
    assign w_osc_sh    = $signed({w_rd_osc[obp_pkg::OSC_W-1], w_rd_osc, 8'h00});

    assign w_in_dia = (w_osc_sh > $signed({2'b00, r_thr_dlo}))
                   && (w_osc_sh < $signed({2'b00, r_thr_dhi}));
    assign w_in_sys = (w_osc_sh > $signed({2'b00, r_thr_slo}))
                   && (w_osc_sh < $signed({2'b00, r_thr_shi}));

    obp_ram #(
        .WIDTH (obp_pkg::RAM_W),
        .DEPTH (obp_pkg::DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.osc),
        .i_wr_addr (r_count[obp_pkg::ADDR_W-1:0]),
        .i_wr_data ({r_p, w_osc}),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_idx[obp_pkg::ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osc_off <= obp_pkg::RST_OSC_OFFSET;
            r_dlo     <= obp_pkg::RST_DIA_RATIO_LOW;
            r_dhi     <= obp_pkg::RST_DIA_RATIO_HIGH;
            r_slo     <= obp_pkg::RST_SYS_RATIO_LOW;
            r_shi     <= obp_pkg::RST_SYS_RATIO_HIGH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                obp_pkg::CFG_OSC_OFFSET:     r_osc_off <= i_cfg_data;
                obp_pkg::CFG_DIA_RATIO_LOW:  r_dlo     <= i_cfg_data;
                obp_pkg::CFG_DIA_RATIO_HIGH: r_dhi     <= i_cfg_data;
                obp_pkg::CFG_SYS_RATIO_LOW:  r_slo     <= i_cfg_data;
                obp_pkg::CFG_SYS_RATIO_HIGH: r_shi     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // record state, cleared when the result is handed over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            for (int k = 0; k < obp_pkg::WIN_LEN; k++) begin
                r_win[k] <= '0;
            end
            r_win_pos <= '0;
            r_win_sum <= '0;
            r_count   <= '0;
            r_max     <= '0;
            r_last    <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_last <= i_last;
                if (o_stat.room) begin
                    r_win[r_win_pos] <= i_pressure;
                    r_win_sum        <= w_sum_next;
                    if (r_win_pos == obp_pkg::WPOS_W'(obp_pkg::WIN_LEN - 1)) begin
                        r_win_pos <= '0;
                    end else begin
                        r_win_pos <= r_win_pos + obp_pkg::WPOS_W'(1);
                    end
                end
            end
            if (i_cmd.osc) begin
                r_count <= r_count + obp_pkg::CNT_W'(1);
                if (r_count >= obp_pkg::CNT_W'(obp_pkg::WIN_LEN) && w_osc > r_max) begin
                    r_max <= w_osc;
                end
            end
        end
    end

    // load payload, band thresholds and scan matches
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p <= i_pressure;
        end
        if (i_cmd.mean) begin
            r_prod <= obp_pkg::PROD_W'(r_win_sum) * obp_pkg::PROD_W'(obp_pkg::RECIP);
        end
        if (i_cmd.prep) begin
            r_thr_dlo <= obp_pkg::THR_W'(r_dlo) * obp_pkg::THR_W'(w_max_mag);
            r_thr_dhi <= obp_pkg::THR_W'(r_dhi) * obp_pkg::THR_W'(w_max_mag);
            r_thr_slo <= obp_pkg::THR_W'(r_slo) * obp_pkg::THR_W'(w_max_mag);
            r_thr_shi <= obp_pkg::THR_W'(r_shi) * obp_pkg::THR_W'(w_max_mag);
        end
        if (i_cmd.prep) begin
            r_sys <= '0;
            r_dia <= '0;
        end else if (r_eval) begin
            if (w_in_dia) begin
                r_dia <= w_rd_sample;
            end else if (!r_sys_f && w_in_sys) begin
                r_sys <= w_rd_sample;
            end
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_eval  <= 1'b0;
            r_sys_f <= 1'b0;
            r_dia_f <= 1'b0;
        end else begin
            r_eval <= i_cmd.rd_en;
            if (i_cmd.prep) begin
                r_idx   <= obp_pkg::CNT_W'(obp_pkg::WIN_LEN);
                r_sys_f <= 1'b0;
                r_dia_f <= 1'b0;
            end else begin
                if (i_cmd.rd_en) begin
                    r_idx <= r_idx + obp_pkg::CNT_W'(1);
                end
                if (r_eval) begin
                    if (w_in_dia) begin
                        r_dia_f <= 1'b1;
                    end else if (w_in_sys) begin
                        r_sys_f <= 1'b1;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_sys  <= r_sys[obp_pkg::P_W-1 -: obp_pkg::OUT_P_W];
            r_o_dia  <= r_dia[obp_pkg::P_W-1 -: obp_pkg::OUT_P_W];
            r_o_sf   <= r_sys_f;
            r_o_df   <= r_dia_f;
            r_o_kept <= r_count;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_systolic_mmhg   = r_o_sys;
    assign o_diastolic_mmhg  = r_o_dia;
    assign o_systolic_found  = r_o_sf;
    assign o_diastolic_found = r_o_df;
    assign o_samples_kept    = r_o_kept;

endmodule

### hdl/oscillometric_bp_estimator.sv
// Oscillometric blood pressure estimator, fixed-ratio method. A record of cuff
// pressure samples (unsigned Q9.8 mmHg) is loaded one transaction at a time;
// each kept sample runs through its load steps (accept and window update,
// reciprocal multiply for the 5-sample mean, oscillation compute with store
// write and maximum update); the input stall is high after each such accept
// until those steps end. Samples past the 2048-entry store are accepted and
// dropped. The transaction marked last starts the scan, which reads the record
// store one entry per cycle through its single read port: after that sample's
// own load steps come threshold setup, one read per entry after the fifth, a
// drain step for the read latency and hand-over (threshold setup and hand-over
// alone for a record too short to scan) before the result transaction is
// offered. The result sits in its own register, so the next record starts
// loading while the result waits; a further last sample waits for it to be
// taken. Configuration writes are accepted every cycle and take effect for the
// following samples and scans; write them while no record is in flight.
// depends on obp_pkg, obp_ctrl, obp_datapath
`timescale 1ns / 1ps

module oscillometric_bp_estimator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [obp_pkg::P_W-1:0]         i_pressure,
    input  logic                            i_last,
    // result output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [obp_pkg::OUT_P_W-1:0]     o_systolic_mmhg,
    output logic [obp_pkg::OUT_P_W-1:0]     o_diastolic_mmhg,
    output logic                            o_systolic_found,
    output logic                            o_diastolic_found,
    output logic [obp_pkg::CNT_W-1:0]       o_samples_kept,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [obp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [obp_pkg::CFG_W-1:0]       i_cfg_data
);

    obp_pkg::t_dp_cmd  w_cmd;
    obp_pkg::t_dp_stat w_stat;

    // registers are plain flops, a write to a defined index always lands
    assign o_cfg_ready = 1'b1;

    // sequencing: one sample at a time, then the scan
    obp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_last),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // window, mean, record store, band tests and result register
    obp_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_pressure        (i_pressure),
        .i_last            (i_last),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_systolic_mmhg   (o_systolic_mmhg),
        .o_diastolic_mmhg  (o_diastolic_mmhg),
        .o_systolic_found  (o_systolic_found),
        .o_diastolic_found (o_diastolic_found),
        .o_samples_kept    (o_samples_kept)
    );

endmodule

### hdl/obp_checker.sv
// port-level checks for the estimator, attached to the top level by bind
// depends on obp_pkg and oscillometric_bp_estimator_macros.svh
`timescale 1ns / 1ps
`include "oscillometric_bp_estimator_macros.svh"

module obp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            i_last,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [obp_pkg::OUT_P_W-1:0]     o_systolic_mmhg,
    input logic                            o_systolic_found,
    input logic                            o_diastolic_found,
    input logic [obp_pkg::CNT_W-1:0]       o_samples_kept
);

    logic w_in_acc;
    logic w_short;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_short  = o_samples_kept <= obp_pkg::CNT_W'(obp_pkg::WIN_LEN);

    // a stalled result stays offered
    `OBP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // an accepted closing sample always leaves the idle state, so input stalls next cycle
    `OBP_ASSERT_NEXT(a_last_stalls, i_clk, i_rst_n, w_in_acc && i_last, o_in_stall)

    // no systolic match means a zero pressure
    `OBP_ASSERT_IMPL(a_sys_zero, i_clk, i_rst_n, o_out_valid && !o_systolic_found, o_systolic_mmhg == '0)

    // a record too short to scan finds nothing
    `OBP_ASSERT_IMPL(a_short_empty, i_clk, i_rst_n, o_out_valid && w_short, !o_systolic_found && !o_diastolic_found)

endmodule

bind oscillometric_bp_estimator obp_checker u_obp_checker (.*);
